>>> rtl/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> rtl/abo_pkg.sv
package abo_pkg;

  // pixel and arithmetic widths
  localparam int CH_N   = 3;
  localparam int PIX_W  = 8;
  localparam int PROD_W = 2 * PIX_W;
  localparam int TRIP_W = 3 * PIX_W;
  localparam int SUM_W  = TRIP_W + 1;
  localparam int NUM_W  = PROD_W + 1;
  localparam int QUO_W  = PIX_W;

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  typedef logic [PIX_W-1:0] pix_t;

  // word handed from cell to cell along the divider chain
  typedef struct packed {
    logic [CH_N-1:0][NUM_W-1:0] rem;
    logic [CH_N-1:0][QUO_W-1:0] quo;
    logic [CH_N-1:0]            ovf;
    pix_t                       ra;
    logic                       bypass;
    pix_t                       bot_alpha;
    logic [CH_N-1:0][PIX_W-1:0] bot_chan;
  } div_word_t;

  // floor(x / 255) for x up to 255^3: shift-add estimate, one correction step
  function automatic logic [PROD_W-1:0] div255(input logic [TRIP_W-1:0] x);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] q;
    logic [SUM_W-1:0] prod;
    logic [SUM_W-1:0] rem;
    sum  = {1'b0, x} + SUM_W'(x >> PIX_W) + SUM_W'(x >> (2 * PIX_W));
    q    = sum >> PIX_W;
    prod = (q << PIX_W) - q;
    rem  = {1'b0, x} - prod;
    if (rem >= SUM_W'(PIX_MAX)) begin
      q = q + SUM_W'(1);
    end
    return q[PROD_W-1:0];
  endfunction

endpackage

>>> rtl/abo_prep.sv
module abo_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  abo_pkg::pix_t     top_alpha,
  input  abo_pkg::pix_t     top_red,
  input  abo_pkg::pix_t     top_green,
  input  abo_pkg::pix_t     top_blue,
  input  abo_pkg::pix_t     bottom_alpha,
  input  abo_pkg::pix_t     bottom_red,
  input  abo_pkg::pix_t     bottom_green,
  input  abo_pkg::pix_t     bottom_blue,
  output logic              dn_valid,
  input  logic              dn_ready,
  output abo_pkg::div_word_t dn_word
);
  import abo_pkg::*;

  localparam int STG_N = 5;
  localparam int RA_W  = PIX_W + 1;

  // legacy alpha rules: zero alpha with color means opaque, alpha of one means clear
  function automatic pix_t adjust_alpha(input pix_t a, input pix_t r, input pix_t g,
                                        input pix_t b);
    pix_t res;
    res = a;
    if (a == '0 && (r | g | b) != '0) begin
      res = PIX_MAX;
    end
    if (res == pix_t'(1)) begin
      res = '0;
    end
    return res;
  endfunction

  logic [STG_N-1:0] v_r, v_nxt, en, v_src;

  // stage handshake: a stage loads when empty or when its successor moves
  always_comb begin
    for (int k = STG_N - 1; k >= 0; k--) begin
      if (k == STG_N - 1) begin
        en[k] = !v_r[k] || dn_ready;
      end else begin
        en[k] = !v_r[k] || en[k+1];
      end
    end
  end

  assign v_src = {v_r[STG_N-2:0], up_valid};

  always_comb begin
    for (int k = 0; k < STG_N; k++) begin
      v_nxt[k] = en[k] ? v_src[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[STG_N-1];

  // stage 1: adjusted alphas
  pix_t da_in, sa_in;
  pix_t top_in [CH_N];
  pix_t bot_in [CH_N];

  assign da_in = adjust_alpha(top_alpha, top_red, top_green, top_blue);
  assign sa_in = adjust_alpha(bottom_alpha, bottom_red, bottom_green, bottom_blue);
  assign top_in[0] = top_red;
  assign top_in[1] = top_green;
  assign top_in[2] = top_blue;
  assign bot_in[0] = bottom_red;
  assign bot_in[1] = bottom_green;
  assign bot_in[2] = bottom_blue;

  pix_t da1_r, sa1_r, ba1_r;
  logic byp1_r;
  pix_t top1_r [CH_N];
  pix_t bot1_r [CH_N];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      da1_r  <= da_in;
      sa1_r  <= sa_in;
      ba1_r  <= bottom_alpha;
      byp1_r <= (da_in == '0);
      for (int c = 0; c < CH_N; c++) begin
        top1_r[c] <= top_in[c];
        bot1_r[c] <= bot_in[c];
      end
    end
  end

  // stage 2: byte products
  logic [PROD_W-1:0] tp2_r [CH_N];
  logic [PROD_W-1:0] bp2_r [CH_N];
  logic [PROD_W-1:0] dsa2_r;
  pix_t da2_r, sa2_r, ba2_r;
  logic byp2_r;
  pix_t bot2_r [CH_N];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dsa2_r <= PROD_W'(da1_r) * PROD_W'(sa1_r);
      da2_r  <= da1_r;
      sa2_r  <= sa1_r;
      ba2_r  <= ba1_r;
      byp2_r <= byp1_r;
      for (int c = 0; c < CH_N; c++) begin
        tp2_r[c]  <= PROD_W'(top1_r[c]) * PROD_W'(da1_r);
        bp2_r[c]  <= PROD_W'(bot1_r[c]) * PROD_W'(sa1_r);
        bot2_r[c] <= bot1_r[c];
      end
    end
  end

  // stage 3: triple products and result alpha
  logic [RA_W-1:0] ra_sum;
  pix_t ra_clamp;

  assign ra_sum   = RA_W'(da2_r) + RA_W'(sa2_r) - RA_W'(div255(TRIP_W'(dsa2_r)));
  assign ra_clamp = (ra_sum > RA_W'(PIX_MAX)) ? PIX_MAX : ra_sum[PIX_W-1:0];

  logic [TRIP_W-1:0] bsd3_r [CH_N];
  logic [PROD_W-1:0] tp3_r [CH_N];
  logic [PROD_W-1:0] bp3_r [CH_N];
  pix_t ra3_r, ba3_r;
  logic byp3_r;
  pix_t bot3_r [CH_N];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ra3_r  <= ra_clamp;
      ba3_r  <= ba2_r;
      byp3_r <= byp2_r;
      for (int c = 0; c < CH_N; c++) begin
        bsd3_r[c] <= TRIP_W'(bp2_r[c]) * TRIP_W'(da2_r);
        tp3_r[c]  <= tp2_r[c];
        bp3_r[c]  <= bp2_r[c];
        bot3_r[c] <= bot2_r[c];
      end
    end
  end

  // stage 4: scale the triple products down by 255
  logic [PROD_W-1:0] q4_r [CH_N];
  logic [PROD_W-1:0] tp4_r [CH_N];
  logic [PROD_W-1:0] bp4_r [CH_N];
  pix_t ra4_r, ba4_r;
  logic byp4_r;
  pix_t bot4_r [CH_N];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ra4_r  <= ra3_r;
      ba4_r  <= ba3_r;
      byp4_r <= byp3_r;
      for (int c = 0; c < CH_N; c++) begin
        q4_r[c]   <= div255(bsd3_r[c]);
        tp4_r[c]  <= tp3_r[c];
        bp4_r[c]  <= bp3_r[c];
        bot4_r[c] <= bot3_r[c];
      end
    end
  end

  // stage 5: numerators and overflow check against ra * 256
  div_word_t word_nxt, word_r;
  logic [NUM_W-1:0] num [CH_N];

  always_comb begin
    word_nxt           = '0;
    word_nxt.ra        = ra4_r;
    word_nxt.bypass    = byp4_r;
    word_nxt.bot_alpha = ba4_r;
    for (int c = 0; c < CH_N; c++) begin
      num[c]              = NUM_W'(tp4_r[c]) + NUM_W'(bp4_r[c]) - NUM_W'(q4_r[c]);
      word_nxt.rem[c]     = num[c];
      word_nxt.ovf[c]     = (num[c] >= (NUM_W'(ra4_r) << QUO_W));
      word_nxt.bot_chan[c] = bot4_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      word_r <= word_nxt;
    end
  end

  assign dn_word = word_r;

endmodule

>>> rtl/abo_div_cell.sv
module abo_div_cell #(
  parameter int BIT = abo_pkg::QUO_W - 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  abo_pkg::div_word_t up_word,
  output logic               dn_valid,
  input  logic               dn_ready,
  output abo_pkg::div_word_t dn_word
);
  import abo_pkg::*;

  logic             valid_r, valid_nxt;
  div_word_t        word_r, word_nxt;
  logic [NUM_W-1:0] dsr;

  // divisor lined up with this cell's quotient bit
  assign dsr = NUM_W'(up_word.ra) << BIT;

  // one restoring step per channel, quotient bit shifted in at the bottom
  always_comb begin
    word_nxt = up_word;
    for (int c = 0; c < CH_N; c++) begin
      if (up_word.rem[c] >= dsr) begin
        word_nxt.rem[c] = up_word.rem[c] - dsr;
        word_nxt.quo[c] = {up_word.quo[c][QUO_W-2:0], 1'b1};
      end else begin
        word_nxt.quo[c] = {up_word.quo[c][QUO_W-2:0], 1'b0};
      end
    end
  end

  // cell handshake
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

>>> rtl/argb_alpha_over_blend_top.sv
// Porter-Duff "over" of a top ARGB8888 pixel onto a bottom one, non-premultiplied.
// Input channel: in_valid/in_ready with the eight top and bottom bytes; one word
// is taken on each edge where both are high. Result channel: out_valid/out_ready
// with out_alpha and the three color bytes.
// Pipeline: 5 front stages, 8 divider cells and 1 output register; the first
// front stage loads on the accepting edge itself.
// Throughput: one pixel per clock unless the receiver stalls and the pipeline
// fills; every stage and divider cell holds one word.
// The quotient is formed by a chain of 8 cells, one quotient bit per cell for all
// three channels, so the cell count sets the latency.
// A stalled receiver holds the output register; words behind it keep moving into
// empty stages, and in_ready drops only once every stage is full.
// Reset (rst_n low, synchronous) empties the pipeline; payload is not cleared.
// A top pixel whose adjusted alpha is zero passes the bottom pixel through
// unchanged; results are clamped to 255.
`include "assert_macros.svh"

module argb_alpha_over_blend_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  abo_pkg::pix_t in_top_alpha,
  input  abo_pkg::pix_t in_top_red,
  input  abo_pkg::pix_t in_top_green,
  input  abo_pkg::pix_t in_top_blue,
  input  abo_pkg::pix_t in_bottom_alpha,
  input  abo_pkg::pix_t in_bottom_red,
  input  abo_pkg::pix_t in_bottom_green,
  input  abo_pkg::pix_t in_bottom_blue,
  output logic          out_valid,
  input  logic          out_ready,
  output abo_pkg::pix_t out_alpha,
  output abo_pkg::pix_t out_red,
  output abo_pkg::pix_t out_green,
  output abo_pkg::pix_t out_blue
);
  import abo_pkg::*;

  // adjusted top alpha is at least two whenever blending happens
  localparam pix_t RA_MIN = pix_t'(2);

  logic [QUO_W:0] cv;
  logic [QUO_W:0] cr;
  div_word_t      cw [QUO_W+1];

  // front stages: alpha rules, products, numerators
  abo_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_valid),
    .up_ready     (in_ready),
    .top_alpha    (in_top_alpha),
    .top_red      (in_top_red),
    .top_green    (in_top_green),
    .top_blue     (in_top_blue),
    .bottom_alpha (in_bottom_alpha),
    .bottom_red   (in_bottom_red),
    .bottom_green (in_bottom_green),
    .bottom_blue  (in_bottom_blue),
    .dn_valid     (cv[0]),
    .dn_ready     (cr[0]),
    .dn_word      (cw[0])
  );

  // divider chain, most significant quotient bit first
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    abo_div_cell #(
      .BIT (QUO_W - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[i]),
      .up_ready (cr[i]),
      .up_word  (cw[i]),
      .dn_valid (cv[i+1]),
      .dn_ready (cr[i+1]),
      .dn_word  (cw[i+1])
    );
  end

  // final pick: pass-through, zero-divisor guard, clamp or quotient
  div_word_t fin;
  pix_t      sel_alpha;
  pix_t      sel_chan [CH_N];

  assign fin = cw[QUO_W];

  always_comb begin
    if (fin.bypass) begin
      sel_alpha = fin.bot_alpha;
    end else begin
      sel_alpha = fin.ra;
    end
    for (int c = 0; c < CH_N; c++) begin
      if (fin.bypass) begin
        sel_chan[c] = fin.bot_chan[c];
      end else if (fin.ra == '0) begin
        sel_chan[c] = '0;
      end else if (fin.ovf[c]) begin
        sel_chan[c] = PIX_MAX;
      end else begin
        sel_chan[c] = fin.quo[c];
      end
    end
  end

  // output register
  logic out_valid_r, out_valid_nxt;
  pix_t alpha_r, red_r, green_r, blue_r;

  assign cr[QUO_W]     = !out_valid_r || out_ready;
  assign out_valid_nxt = cr[QUO_W] ? cv[QUO_W] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cr[QUO_W] && cv[QUO_W]) begin
      alpha_r <= sel_alpha;
      red_r   <= sel_chan[0];
      green_r <= sel_chan[1];
      blue_r  <= sel_chan[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_alpha = alpha_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // per channel: clamped, or remainder left below the divisor
  logic [CH_N-1:0] rem_ok;

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      rem_ok[c] = fin.ovf[c] || (fin.rem[c] < NUM_W'(fin.ra));
    end
  end

  // input backs up only when every stage is full and the receiver stalls
  `ASSERT_IMPL(a_block_only_when_full, !in_ready, out_valid && !out_ready, "input blocked with room in pipeline")

  // blended result alpha never drops below two, the floor of the adjusted top alpha
  `ASSERT_IMPL(a_ra_floor, cv[QUO_W] && !fin.bypass, fin.ra >= RA_MIN, "blend alpha below two")

  // divider ends with a remainder below the divisor unless clamped
  `ASSERT_IMPL(a_rem_below_divisor, cv[QUO_W] && !fin.bypass, &rem_ok, "divider remainder too large")

endmodule
